### rtl/rmq_pkg.sv
package rmq_pkg;

   localparam int FRAC_BITS_DEF  = 14;
   localparam int DATA_WIDTH_DEF = 16;

   // Non-dominant components are divided in parallel lanes
   localparam int NUM_LANES = 3;

   typedef enum logic [1:0] {
      BR_TRACE = 2'd0,
      BR_COL0  = 2'd1,
      BR_COL1  = 2'd2,
      BR_COL2  = 2'd3
   } branch_type;

endpackage

### rtl/rmq_req_if.sv
interface rmq_req_if #(
   parameter int DW = rmq_pkg::DATA_WIDTH_DEF
);
   logic                 valid;
   logic                 ready;
   logic signed [DW-1:0] a00;
   logic signed [DW-1:0] a01;
   logic signed [DW-1:0] a02;
   logic signed [DW-1:0] a10;
   logic signed [DW-1:0] a11;
   logic signed [DW-1:0] a12;
   logic signed [DW-1:0] a20;
   logic signed [DW-1:0] a21;
   logic signed [DW-1:0] a22;

   modport source (
      output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
      input  ready
   );
   modport sink (
      input  valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
      output ready
   );
endinterface

### rtl/rmq_rsp_if.sv
interface rmq_rsp_if #(
   parameter int DW = rmq_pkg::DATA_WIDTH_DEF
);
   logic                 valid;
   logic                 ready;
   logic signed [DW-1:0] qw;
   logic signed [DW-1:0] qx;
   logic signed [DW-1:0] qy;
   logic signed [DW-1:0] qz;
   logic [1:0]           branch_used;

   modport source (
      output valid, qw, qx, qy, qz, branch_used,
      input  ready
   );
   modport sink (
      input  valid, qw, qx, qy, qz, branch_used,
      output ready
   );
endinterface

### rtl/rotation_matrix_to_quaternion_top.sv
// Channel  Dir  Payload                               Transfer
// req      in   a00 a01 a02 a10 a11 a12 a20 a21 a22   req.valid & req.ready
// rsp      out  qw qx qy qz branch_used               rsp.valid & rsp.ready
//
// One item per cycle unless rsp stalls. Input register, SW = (RADW+FRAC_BITS+1)/2
// square-root cells, divider setup register, DVW = DATA_WIDTH+FRAC_BITS+1 divider
// cells and output register in a row. Synchronous reset clears the valid bits only.
// A stalled result holds the whole row of cells; req.ready drops only then.
module rotation_matrix_to_quaternion_top #(
   parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF,
   parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF
) (
   input logic       clock,
   input logic       reset,
   rmq_req_if.sink   req,
   rmq_rsp_if.source rsp
);
   localparam int NL   = rmq_pkg::NUM_LANES;
   localparam int DW   = DATA_WIDTH;
   localparam int NW   = DW + 1;
   localparam int RW   = ((DW > FRAC_BITS + 1) ? DW : FRAC_BITS + 1) + 3;
   localparam int RADW = RW - 1;
   localparam int SW   = (RADW + FRAC_BITS + 1) / 2;
   localparam int VW   = 2 * SW;
   localparam int DVW  = DW + FRAC_BITS + 1;
   localparam int PWS  = NL * NW + 2;
   localparam int PWD  = NL + SW + 2;

   localparam logic signed [RW-1:0] ONE     = RW'(1) << FRAC_BITS;
   localparam logic [DVW-1:0]       POS_LIM = (DVW'(1) << (DW - 1)) - DVW'(1);
   localparam logic [DVW-1:0]       NEG_LIM = DVW'(1) << (DW - 1);

   logic en;
   logic rsp_valid_ff;

   assign en        = !rsp_valid_ff || rsp.ready;
   assign req.ready = en;

   // ---------------- front end: branch select, radicand, numerators
   logic signed [RW-1:0] e00, e11, e22, trace, rad_s;
   logic signed [NW-1:0] d12m, d20m, d01m, s01, s20, s12;
   logic signed [NW-1:0] n_c [NL];
   rmq_pkg::branch_type  br_c;

   always_comb begin
      e00   = RW'(req.a00);
      e11   = RW'(req.a11);
      e22   = RW'(req.a22);
      trace = ONE + e00 + e11 + e22;
      d12m  = NW'(req.a12) - NW'(req.a21);
      d20m  = NW'(req.a20) - NW'(req.a02);
      d01m  = NW'(req.a01) - NW'(req.a10);
      s01   = NW'(req.a01) + NW'(req.a10);
      s20   = NW'(req.a20) + NW'(req.a02);
      s12   = NW'(req.a12) + NW'(req.a21);
      if (trace >= RW'(1)) begin
         br_c   = rmq_pkg::BR_TRACE;
         rad_s  = trace;
         n_c[0] = d12m;
         n_c[1] = d20m;
         n_c[2] = d01m;
      end else if (req.a00 > req.a11 && req.a00 > req.a22) begin
         br_c   = rmq_pkg::BR_COL0;
         rad_s  = ONE + e00 - e11 - e22;
         n_c[0] = s01;
         n_c[1] = s20;
         n_c[2] = d12m;
      end else if (req.a11 > req.a22) begin
         br_c   = rmq_pkg::BR_COL1;
         rad_s  = ONE + e11 - e00 - e22;
         n_c[0] = s01;
         n_c[1] = s12;
         n_c[2] = d20m;
      end else begin
         br_c   = rmq_pkg::BR_COL2;
         rad_s  = ONE + e22 - e00 - e11;
         n_c[0] = s20;
         n_c[1] = s12;
         n_c[2] = d01m;
      end
      // clamp a nonpositive radicand to one LSB
      if (rad_s < RW'(1)) begin
         rad_s = RW'(1);
      end
   end

   logic              vld_a_ff;
   logic [RADW-1:0]   rad_a_ff;
   logic [PWS-1:0]    side_a_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
      end else if (en) begin
         vld_a_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_a_ff  <= rad_s[RADW-1:0];
         side_a_ff <= {br_c, n_c[2], n_c[1], n_c[0]};
      end
   end

   // ---------------- square-root row
   logic           sq_vld  [SW+1];
   logic [SW-1:0]  sq_root [SW+1];
   logic [SW+1:0]  sq_rem  [SW+1];
   logic [VW-1:0]  sq_val  [SW+1];
   logic [PWS-1:0] sq_side [SW+1];

   assign sq_vld[0]  = vld_a_ff;
   assign sq_root[0] = '0;
   assign sq_rem[0]  = '0;
   assign sq_val[0]  = VW'(rad_a_ff) << FRAC_BITS;
   assign sq_side[0] = side_a_ff;

   for (genvar i = 0; i < SW; i++) begin : g_sqrt
      rmq_sqrt_cell #(.SW(SW), .VW(VW), .PW(PWS)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .up_vld  (sq_vld[i]),
         .up_root (sq_root[i]),
         .up_rem  (sq_rem[i]),
         .up_val  (sq_val[i]),
         .up_side (sq_side[i]),
         .dn_vld  (sq_vld[i+1]),
         .dn_root (sq_root[i+1]),
         .dn_rem  (sq_rem[i+1]),
         .dn_val  (sq_val[i+1]),
         .dn_side (sq_side[i+1])
      );
   end

   // ---------------- divider setup: magnitudes scaled, rounding offset r/2
   logic [SW-1:0]    root_q;
   logic [SW-1:0]    big_c;
   logic [NL*DVW-1:0] dvd_c;
   logic [NL-1:0]    sgn_c;
   logic [1:0]       br_q;

   assign root_q = sq_root[SW];
   assign br_q   = sq_side[SW][PWS-1 -: 2];
   assign big_c  = SW'(({1'b0, root_q} + (SW+1)'(1)) >> 1);

   for (genvar l = 0; l < NL; l++) begin : g_prep
      logic signed [NW-1:0] n;
      logic [NW-1:0]        mag;
      always_comb begin
         n        = sq_side[SW][l*NW +: NW];
         mag      = n[NW-1] ? NW'(-n) : NW'(n);
         sgn_c[l] = n[NW-1];
         dvd_c[l*DVW +: DVW] = (DVW'(mag) << (FRAC_BITS - 1)) + DVW'(root_q >> 1);
      end
   end

   logic              vld_b_ff;
   logic [SW-1:0]     root_b_ff;
   logic [NL*DVW-1:0] dvd_b_ff;
   logic [PWD-1:0]    side_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_b_ff <= 1'b0;
      end else if (en) begin
         vld_b_ff <= sq_vld[SW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         root_b_ff <= root_q;
         dvd_b_ff  <= dvd_c;
         side_b_ff <= {br_q, big_c, sgn_c};
      end
   end

   // ---------------- divider row
   logic              dv_vld  [DVW+1];
   logic [SW-1:0]     dv_div  [DVW+1];
   logic [NL*SW-1:0]  dv_rem  [DVW+1];
   logic [NL*DVW-1:0] dv_dvd  [DVW+1];
   logic [PWD-1:0]    dv_side [DVW+1];

   assign dv_vld[0]  = vld_b_ff;
   assign dv_div[0]  = root_b_ff;
   assign dv_rem[0]  = '0;
   assign dv_dvd[0]  = dvd_b_ff;
   assign dv_side[0] = side_b_ff;

   for (genvar i = 0; i < DVW; i++) begin : g_div
      rmq_div_cell #(.SW(SW), .DVW(DVW), .PW(PWD)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .up_vld  (dv_vld[i]),
         .up_div  (dv_div[i]),
         .up_rem  (dv_rem[i]),
         .up_dvd  (dv_dvd[i]),
         .up_side (dv_side[i]),
         .dn_vld  (dv_vld[i+1]),
         .dn_div  (dv_div[i+1]),
         .dn_rem  (dv_rem[i+1]),
         .dn_dvd  (dv_dvd[i+1]),
         .dn_side (dv_side[i+1])
      );
   end

   // ---------------- output: place components, apply sign, saturate
   function automatic logic [DW-1:0] sat_mag(input logic [DVW-1:0] q, input logic neg);
      logic [DW-1:0] res;
      if (!neg) begin
         res = (q > POS_LIM) ? {1'b0, {(DW-1){1'b1}}} : q[DW-1:0];
      end else begin
         res = (q > NEG_LIM) ? {1'b1, {(DW-1){1'b0}}} : DW'(~q[DW-1:0] + 1'b1);
      end
      return res;
   endfunction

   logic [DVW-1:0]      q_l [NL];
   logic [NL-1:0]       sgn_d;
   logic [DVW-1:0]      big_d;
   rmq_pkg::branch_type br_d;
   logic [DVW-1:0]      mw, mx, my, mz;
   logic                sw_n, sx_n, sy_n, sz_n;

   always_comb begin
      for (int l = 0; l < NL; l++) begin
         q_l[l] = dv_dvd[DVW][l*DVW +: DVW];
      end
      sgn_d = dv_side[DVW][NL-1:0];
      big_d = DVW'(dv_side[DVW][NL +: SW]);
      br_d  = rmq_pkg::branch_type'(dv_side[DVW][PWD-1 -: 2]);
      case (br_d)
         rmq_pkg::BR_TRACE: begin
            mw = big_d;  sw_n = 1'b0;
            mx = q_l[0]; sx_n = sgn_d[0];
            my = q_l[1]; sy_n = sgn_d[1];
            mz = q_l[2]; sz_n = sgn_d[2];
         end
         rmq_pkg::BR_COL0: begin
            mx = big_d;  sx_n = 1'b0;
            my = q_l[0]; sy_n = sgn_d[0];
            mz = q_l[1]; sz_n = sgn_d[1];
            mw = q_l[2]; sw_n = sgn_d[2];
         end
         rmq_pkg::BR_COL1: begin
            mx = q_l[0]; sx_n = sgn_d[0];
            my = big_d;  sy_n = 1'b0;
            mz = q_l[1]; sz_n = sgn_d[1];
            mw = q_l[2]; sw_n = sgn_d[2];
         end
         default: begin
            mx = q_l[0]; sx_n = sgn_d[0];
            my = q_l[1]; sy_n = sgn_d[1];
            mz = big_d;  sz_n = 1'b0;
            mw = q_l[2]; sw_n = sgn_d[2];
         end
      endcase
   end

   logic [DW-1:0] qw_ff, qx_ff, qy_ff, qz_ff;
   logic [1:0]    br_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_vld[DVW];
      end
   end

   // the vector part leaves negated
   always_ff @(posedge clock) begin
      if (en) begin
         qw_ff <= sat_mag(mw, sw_n);
         qx_ff <= sat_mag(mx, !sx_n);
         qy_ff <= sat_mag(my, !sy_n);
         qz_ff <= sat_mag(mz, !sz_n);
         br_ff <= br_d;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.qw          = qw_ff;
   assign rsp.qx          = qx_ff;
   assign rsp.qy          = qy_ff;
   assign rsp.qz          = qz_ff;
   assign rsp.branch_used = br_ff;
endmodule

### rtl/rmq_sqrt_cell.sv
module rmq_sqrt_cell #(
   parameter int SW = 16,
   parameter int VW = 32,
   parameter int PW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          up_vld,
   input  logic [SW-1:0] up_root,
   input  logic [SW+1:0] up_rem,
   input  logic [VW-1:0] up_val,
   input  logic [PW-1:0] up_side,
   output logic          dn_vld,
   output logic [SW-1:0] dn_root,
   output logic [SW+1:0] dn_rem,
   output logic [VW-1:0] dn_val,
   output logic [PW-1:0] dn_side
);
   logic          vld_ff;
   logic [SW-1:0] root_ff, root_in;
   logic [SW+1:0] rem_ff, rem_in;
   logic [VW-1:0] val_ff, val_in;
   logic [PW-1:0] side_ff;
   logic [SW+3:0] rem_t;
   logic [SW+3:0] trial;
   logic          ge;

   // one result bit per cell: bring down two radicand bits, try 4*root+1
   always_comb begin
      rem_t   = {up_rem, up_val[VW-1 -: 2]};
      trial   = {2'b00, up_root, 2'b01};
      ge      = (rem_t >= trial);
      rem_in  = ge ? (SW+2)'(rem_t - trial) : (SW+2)'(rem_t);
      root_in = {up_root[SW-2:0], ge};
      val_in  = {up_val[VW-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= up_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         root_ff <= root_in;
         rem_ff  <= rem_in;
         val_ff  <= val_in;
         side_ff <= up_side;
      end
   end

   assign dn_vld  = vld_ff;
   assign dn_root = root_ff;
   assign dn_rem  = rem_ff;
   assign dn_val  = val_ff;
   assign dn_side = side_ff;
endmodule

### rtl/rmq_div_cell.sv
module rmq_div_cell #(
   parameter int SW  = 16,
   parameter int DVW = 31,
   parameter int PW  = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              up_vld,
   input  logic [SW-1:0]                     up_div,
   input  logic [rmq_pkg::NUM_LANES*SW-1:0]  up_rem,
   input  logic [rmq_pkg::NUM_LANES*DVW-1:0] up_dvd,
   input  logic [PW-1:0]                     up_side,
   output logic                              dn_vld,
   output logic [SW-1:0]                     dn_div,
   output logic [rmq_pkg::NUM_LANES*SW-1:0]  dn_rem,
   output logic [rmq_pkg::NUM_LANES*DVW-1:0] dn_dvd,
   output logic [PW-1:0]                     dn_side
);
   localparam int NL = rmq_pkg::NUM_LANES;

   logic                vld_ff;
   logic [SW-1:0]       div_ff;
   logic [NL*SW-1:0]    rem_ff, rem_in;
   logic [NL*DVW-1:0]   dvd_ff, dvd_in;
   logic [PW-1:0]       side_ff;

   // one restoring step per lane; quotient bits shift in behind the dividend
   for (genvar l = 0; l < NL; l++) begin : g_lane
      logic [SW:0] rem_t;
      logic        ge;
      always_comb begin
         rem_t = {up_rem[l*SW +: SW], up_dvd[l*DVW + DVW-1]};
         ge    = (rem_t >= {1'b0, up_div});
         rem_in[l*SW +: SW]   = ge ? SW'(rem_t - {1'b0, up_div}) : SW'(rem_t);
         dvd_in[l*DVW +: DVW] = {up_dvd[l*DVW +: DVW-1], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= up_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         div_ff  <= up_div;
         rem_ff  <= rem_in;
         dvd_ff  <= dvd_in;
         side_ff <= up_side;
      end
   end

   assign dn_vld  = vld_ff;
   assign dn_div  = div_ff;
   assign dn_rem  = rem_ff;
   assign dn_dvd  = dvd_ff;
   assign dn_side = side_ff;
endmodule
